FILE: hw/rtl/upex_pkg.sv
// Shared types, register indexes and character helpers for the URL percent-encoder.
`default_nettype none

package upex_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAFE_SET_0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAFE_SET_1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SAFE_SET_2 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SAFE_SET_3 = 3'd5;

    localparam logic [7:0] CH_PERCENT = 8'h25;

    // Beat position within one output run
    typedef enum logic [1:0] {
        PH_FIRST = 2'd0,   // pass-through byte or '%'
        PH_HI    = 2'd1,   // upper hex digit
        PH_LO    = 2'd2    // lower hex digit
    } t_phase;

    // Letters, digits and the fixed punctuation set
    function automatic logic fixed_safe(input logic [7:0] c);
        logic alnum;
        alnum = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A)
             || (c >= 8'h30 && c <= 8'h39);
        unique case (c)
            8'h2C, 8'h2E, 8'h2F, 8'h3B, 8'h27, 8'h5B, 8'h5D, 8'h5C, 8'h2D, 8'h60,
            8'h7E, 8'h21, 8'h24, 8'h5E, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h7B, 8'h7D,
            8'h7C, 8'h3A: return 1'b1;
            default:      return alnum;
        endcase
    endfunction

    // Upper-case ASCII hex digit
    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        if (v < 4'd10) begin
            return 8'h30 + {4'd0, v};
        end else begin
            return 8'h41 + {4'd0, v} - 8'd10;
        end
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/url_percent_encoder_xor.sv
// Top level: XOR-masked URL percent-encoder, one text byte in, one or three characters out.
`default_nettype none

// Channel   Dir  Handshake             Payload
// s (text)  in   i_s_tvalid/o_s_tready tdata[7:0] text_byte, tlast end_of_text
// m (char)  out  o_m_tvalid/i_m_tready tdata[7:0] out_byte, tlast last_of_run,
//                                       tuser text_done
// cfg       in   i_cfg_we (no wait)    i_cfg_idx register index, i_cfg_data value
//
// A text byte takes one output beat when it passes through and three when it
// is escaped; the output beat count sets the sustained rate. Two register
// stages: the key mask is applied as the beat is taken, the safe-set lookup
// sits between the input and the output register; the first character shows
// once the byte has moved from the input to the output register. While a run
// waits on the output, the input register takes one more beat, then tready
// stays low until the run's last beat goes out. Synchronous active-low reset
// clears the key, length, bitmap, key index and both valid flags.

module url_percent_encoder_xor #(
    parameter int unsigned KEY_BYTES_MAX = 8   // 1 to 8
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // text stream
    input  wire                                 i_s_tvalid,
    output logic                                o_s_tready,
    input  wire  [7:0]                          i_s_tdata,   // [7:0] text_byte
    input  wire                                 i_s_tlast,   // end_of_text
    // character stream
    output logic                                o_m_tvalid,
    input  wire                                 i_m_tready,
    output logic [7:0]                          o_m_tdata,   // [7:0] out_byte
    output logic                                o_m_tlast,   // last_of_run
    output logic                                o_m_tuser,   // [0] text_done
    // configuration writes
    input  wire                                 i_cfg_we,
    input  wire  [upex_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [upex_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import upex_pkg::*;

    localparam int unsigned KEY_W   = KEY_BYTES_MAX * 8;
    localparam logic [3:0]  LEN_MAX = 4'(KEY_BYTES_MAX);

    // configuration
    logic [KEY_W-1:0] r_key,     n_key;
    logic [3:0]       r_key_len, n_key_len;
    logic [255:0]     r_safe,    n_safe;

    // key position
    logic [2:0]       r_kidx,    n_kidx;

    // input stage: masked byte
    logic             r_a_vld,   n_a_vld;
    logic [7:0]       r_a_byte,  n_a_byte;
    logic             r_a_eot,   n_a_eot;

    // output stage: one run of beats
    logic             r_o_vld,   n_o_vld;
    logic [7:0]       r_o_byte,  n_o_byte;
    logic             r_o_esc,   n_o_esc;
    logic             r_o_eot,   n_o_eot;
    t_phase           r_o_ph,    n_o_ph;

    logic [63:0]      key64;
    logic [3:0]       len_eff;
    logic [3:0]       kidx_inc;
    logic [7:0]       key_byte;
    logic             s_take;
    logic             o_last;
    logic             o_free;
    logic             a_move;

    always_comb begin
        key64    = 64'(r_key);
        len_eff  = (r_key_len > LEN_MAX) ? LEN_MAX : r_key_len;
        kidx_inc = {1'b0, r_kidx} + 4'd1;
        key_byte = key64[{r_kidx, 3'b000} +: 8];

        o_last = !r_o_esc || (r_o_ph == PH_LO);
        o_free = !r_o_vld || (i_m_tready && o_last);
        a_move = r_a_vld && o_free;
        o_s_tready = !r_a_vld || o_free;
        s_take = i_s_tvalid && o_s_tready;

        unique case (r_o_ph)
            PH_FIRST: o_m_tdata = r_o_esc ? CH_PERCENT : r_o_byte;
            PH_HI:    o_m_tdata = hex_digit(r_o_byte[7:4]);
            PH_LO:    o_m_tdata = hex_digit(r_o_byte[3:0]);
            default:  o_m_tdata = r_o_byte;
        endcase
        o_m_tvalid = r_o_vld;
        o_m_tlast  = o_last;
        o_m_tuser  = o_last && r_o_eot;
    end

    always_comb begin
        n_key     = r_key;
        n_key_len = r_key_len;
        n_safe    = r_safe;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_KEY_BYTES:  n_key          = i_cfg_data[KEY_W-1:0];
                REG_KEY_LENGTH: n_key_len      = i_cfg_data[3:0];
                REG_SAFE_SET_0: n_safe[63:0]   = i_cfg_data;
                REG_SAFE_SET_1: n_safe[127:64] = i_cfg_data;
                REG_SAFE_SET_2: n_safe[191:128] = i_cfg_data;
                REG_SAFE_SET_3: n_safe[255:192] = i_cfg_data;
                default: ;   // writes past the list are dropped
            endcase
        end

        // mask and key advance happen as the beat is taken
        n_kidx   = r_kidx;
        n_a_vld  = r_a_vld && !a_move;
        n_a_byte = r_a_byte;
        n_a_eot  = r_a_eot;
        if (s_take) begin
            n_a_vld  = 1'b1;
            n_a_eot  = i_s_tlast;
            n_a_byte = i_s_tdata;
            if (len_eff != 4'd0) begin
                n_a_byte = i_s_tdata ^ key_byte;
                // an index left past a shortened key is used once, then wraps
                n_kidx   = (kidx_inc >= len_eff) ? 3'd0 : kidx_inc[2:0];
            end
            if (i_s_tlast) begin
                n_kidx = 3'd0;
            end
        end

        n_o_vld  = r_o_vld;
        n_o_byte = r_o_byte;
        n_o_esc  = r_o_esc;
        n_o_eot  = r_o_eot;
        n_o_ph   = r_o_ph;
        if (a_move) begin
            n_o_vld  = 1'b1;
            n_o_byte = r_a_byte;
            n_o_esc  = !(fixed_safe(r_a_byte) || r_safe[r_a_byte]);
            n_o_eot  = r_a_eot;
            n_o_ph   = PH_FIRST;
        end else if (o_free) begin
            n_o_vld  = 1'b0;
        end else if (i_m_tready) begin
            // mid-escape beat taken, step to the next digit
            n_o_ph = (r_o_ph == PH_FIRST) ? PH_HI : PH_LO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key     <= '0;
            r_key_len <= '0;
            r_safe    <= '0;
            r_kidx    <= '0;
            r_a_vld   <= 1'b0;
            r_o_vld   <= 1'b0;
            r_o_ph    <= PH_FIRST;
        end else begin
            r_key     <= n_key;
            r_key_len <= n_key_len;
            r_safe    <= n_safe;
            r_kidx    <= n_kidx;
            r_a_vld   <= n_a_vld;
            r_o_vld   <= n_o_vld;
            r_o_ph    <= n_o_ph;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_byte <= n_a_byte;
        r_a_eot  <= n_a_eot;
        r_o_byte <= n_o_byte;
        r_o_esc  <= n_o_esc;
        r_o_eot  <= n_o_eot;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/upex_chk.sv
// Port-level checker for the percent-encoder, bound to the top level.
`default_nettype none

module upex_chk (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       o_m_tvalid,
    input wire       i_m_tready,
    input wire [7:0] o_m_tdata,
    input wire       o_m_tlast,
    input wire       o_m_tuser
);
    import upex_pkg::*;

    // nothing shows right after reset
    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tlast) && $stable(o_m_tuser))
        else $error("stalled beat changed");

    // text_done only on the closing beat of a run
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tlast)
        else $error("text_done off the last beat");

    // an escape sequence runs without gaps
    a_esc_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && !o_m_tlast |=> o_m_tvalid)
        else $error("gap inside escape sequence");

    // inner beats of a run are '%' or a hex digit
    a_esc_chars: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |->
            (o_m_tdata == CH_PERCENT)
            || (o_m_tdata >= 8'h30 && o_m_tdata <= 8'h39)
            || (o_m_tdata >= 8'h41 && o_m_tdata <= 8'h46))
        else $error("bad character inside escape sequence");

endmodule

bind url_percent_encoder_xor upex_chk u_upex_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire

FILE: verif/upex_checker.sv
// Checker for the URL percent-encoder: tracks the registers, predicts each character, compares.
`timescale 1ns / 100ps

module upex_checker #(
    parameter int unsigned KEY_BYTES_MAX = 8
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_s_tvalid,
    input  wire                                 i_s_tready,
    input  wire  [7:0]                          i_s_tdata,   // [7:0] text_byte
    input  wire                                 i_s_tlast,   // end_of_text
    input  wire                                 i_m_tvalid,
    input  wire                                 i_m_tready,
    input  wire  [7:0]                          i_m_tdata,   // [7:0] out_byte
    input  wire                                 i_m_tlast,   // last_of_run
    input  wire                                 i_m_tuser,   // [0] text_done
    input  wire                                 i_cfg_we,
    input  wire  [upex_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [upex_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_chars_pending,
    output int                                  o_bytes_seen,
    output int                                  o_escapes_seen,
    output int                                  o_chars_checked
);
    import upex_pkg::*;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       text_done;
    } t_char;

    t_char        char_q[$];
    logic [63:0]  key_reg;
    logic [3:0]   key_len_reg;
    logic [255:0] safe_map;
    logic [2:0]   key_pos;

    // letters, digits and the fixed punctuation
    function automatic logic is_plain(input logic [7:0] c);
        string marks;
        logic  hit;
        marks = ",./;'[]\\-~!$^*()_{}|:";
        hit = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9");
        hit |= (c == 8'h60);   // grave accent
        for (int k = 0; k < marks.len(); k++) begin
            if (marks[k] == c) hit = 1'b1;
        end
        return hit;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? 8'h30 + n : 8'h37 + n;
    endfunction

    // mask, advance key position, then queue one or three characters
    task automatic encode_byte(input logic [7:0] raw, input logic eot);
        logic [7:0] c;
        logic [3:0] eff_len;
        logic [3:0] nxt;
        c = raw;
        eff_len = (key_len_reg > KEY_BYTES_MAX) ? 4'(KEY_BYTES_MAX) : key_len_reg;
        if (eff_len != 4'd0) begin
            c ^= key_reg[key_pos*8 +: 8];
            nxt = {1'b0, key_pos} + 4'd1;
            key_pos = (nxt >= eff_len) ? 3'd0 : nxt[2:0];
        end
        if (eot) key_pos = 3'd0;
        if (is_plain(c) || safe_map[c]) begin
            char_q.push_back('{c, 1'b1, eot});
        end else begin
            char_q.push_back('{CH_PERCENT, 1'b0, 1'b0});
            char_q.push_back('{hex_char(c[7:4]), 1'b0, 1'b0});
            char_q.push_back('{hex_char(c[3:0]), 1'b1, eot});
            o_escapes_seen <= o_escapes_seen + 1;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_char want;
        if (!i_rst_n) begin
            key_reg     = '0;
            key_len_reg = '0;
            safe_map    = '0;
            key_pos     = '0;
            char_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_KEY_BYTES:  key_reg          = i_cfg_data;
                    REG_KEY_LENGTH: key_len_reg      = i_cfg_data[3:0];
                    REG_SAFE_SET_0: safe_map[63:0]   = i_cfg_data;
                    REG_SAFE_SET_1: safe_map[127:64] = i_cfg_data;
                    REG_SAFE_SET_2: safe_map[191:128] = i_cfg_data;
                    REG_SAFE_SET_3: safe_map[255:192] = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                encode_byte(i_s_tdata, i_s_tlast);
                o_bytes_seen <= o_bytes_seen + 1;
            end
            if (i_m_tvalid && i_m_tready) begin
                if (char_q.size() == 0) begin
                    $error("unexpected char beat: out_byte %h last_of_run %b text_done %b",
                           i_m_tdata, i_m_tlast, i_m_tuser);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = char_q.pop_front();
                    o_chars_checked <= o_chars_checked + 1;
                    if (i_m_tdata !== want.out_byte || i_m_tlast !== want.last_of_run
                            || i_m_tuser !== want.text_done) begin
                        o_fail_count <= o_fail_count + 1;
                        if (i_m_tdata !== want.out_byte)
                            $error("out_byte: expected %h, got %h", want.out_byte, i_m_tdata);
                        if (i_m_tlast !== want.last_of_run)
                            $error("last_of_run: expected %b, got %b",
                                   want.last_of_run, i_m_tlast);
                        if (i_m_tuser !== want.text_done)
                            $error("text_done: expected %b, got %b", want.text_done, i_m_tuser);
                    end
                end
            end
        end
        o_chars_pending <= char_q.size();
    end

endmodule

FILE: verif/testbench.sv
// Testbench top: drives text beats, register writes and output back-pressure; reports the verdict.
`timescale 1ns / 100ps

module testbench;
    import upex_pkg::*;

    localparam int unsigned KEY_BYTES_MAX = 8;
    // index past the register list, must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    // settle time after the last char: two register stages plus margin
    localparam int DRAIN_CYCLES = 6;
    localparam int RANDOM_ITEMS = 312;

    logic                  clk;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata  = '0;      // [7:0] text_byte
    logic                  s_tlast  = 1'b0;    // end_of_text
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            m_tdata;            // [7:0] out_byte
    logic                  m_tlast;            // last_of_run
    logic                  m_tuser;            // [0] text_done
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int fail_count;
    int chars_pending;
    int bytes_seen;
    int escapes_seen;
    int chars_checked;
    int items_sent;
    int settings_used;
    bit steady;        // when set, neither side idles

    url_percent_encoder_xor #(
        .KEY_BYTES_MAX (KEY_BYTES_MAX)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast),
        .o_m_tuser  (m_tuser),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    upex_checker #(
        .KEY_BYTES_MAX (KEY_BYTES_MAX)
    ) u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_tvalid      (s_tvalid),
        .i_s_tready      (s_tready),
        .i_s_tdata       (s_tdata),
        .i_s_tlast       (s_tlast),
        .i_m_tvalid      (m_tvalid),
        .i_m_tready      (m_tready),
        .i_m_tdata       (m_tdata),
        .i_m_tlast       (m_tlast),
        .i_m_tuser       (m_tuser),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_chars_pending (chars_pending),
        .o_bytes_seen    (bytes_seen),
        .o_escapes_seen  (escapes_seen),
        .o_chars_checked (chars_checked)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // hard stop well past the slowest legal run
    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Output side: per beat, a random stall with ready low, then ready held
    // high until a char beat goes through.
    initial begin : char_sink
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // One text beat. Valid stays high into the next beat when there is no gap,
    // so it is only lowered ahead of an idle stretch.
    task automatic send_byte(input logic [7:0] b, input logic eot);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eot;
        do @(posedge clk); while (!s_tready);
        items_sent++;
    endtask

    // Stop input and wait until every predicted char has come out.
    // First edge lets the checker's count catch up with the last accept.
    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (chars_pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // write enable stays high across back-to-back writes; cfg_done drops it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    task automatic cfg_done;
        cfg_we <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    task automatic load_all(input logic [63:0] key, input logic [3:0] len,
                            input logic [63:0] s0, input logic [63:0] s1,
                            input logic [63:0] s2, input logic [63:0] s3);
        drain();
        write_reg(REG_KEY_BYTES, key);
        write_reg(REG_KEY_LENGTH, {60'd0, len});
        write_reg(REG_SAFE_SET_0, s0);
        write_reg(REG_SAFE_SET_1, s1);
        write_reg(REG_SAFE_SET_2, s2);
        write_reg(REG_SAFE_SET_3, s3);
        cfg_done();
    endtask

    function automatic logic [63:0] rand64;
        return {$urandom, $urandom};
    endfunction

    initial begin : stimulus
        int text_len;
        int target;
        logic [7:0] b;
        logic [3:0] len;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: no mask, empty bitmap. Zero byte, 0xFF, range
        // edges of the alphanumerics, a few punctuation marks, unsafe chars.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte("a", 1'b0);
        send_byte("z", 1'b0);
        send_byte("A", 1'b0);
        send_byte("Z", 1'b0);
        send_byte("0", 1'b0);
        send_byte("9", 1'b0);
        send_byte("~", 1'b0);
        send_byte("_", 1'b0);
        send_byte(8'h20, 1'b0);
        send_byte(CH_PERCENT, 1'b1);

        // 3-byte key; bitmap marks 0x00 and space safe. First byte masks to zero.
        load_all(64'h0123_4567_89AB_CDEF, 4'd3, 64'h0000_0001_0000_0001, '0, '0, '0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hED, 1'b0);
        send_byte(8'hAB, 1'b0);
        send_byte(8'h00, 1'b1);

        // Write past the register list must be a no-op; length 15 acts as 8.
        drain();
        write_reg(REG_UNUSED, '1);
        write_reg(REG_KEY_LENGTH, 64'd15);
        write_reg(REG_SAFE_SET_3, '1);
        cfg_done();
        for (int k = 0; k < 6; k++) send_byte(8'(8'hC0 + k), 1'b0);

        // Shrink the key below the current position: byte 6 used once, then wrap.
        drain();
        write_reg(REG_KEY_LENGTH, 64'd2);
        cfg_done();
        send_byte(8'h41, 1'b0);
        send_byte(8'h7F, 1'b1);

        // Random texts over six settings, extremes first.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: load_all('0, 4'd0, '0, '0, '0, '0);
                1: load_all('1, 4'd8, '0, '0, '0, '0);
                2: load_all(rand64(), 4'd15, '1, '1, '1, '1);
                default: begin
                    len = 4'($urandom_range(0, 15));
                    load_all(rand64(), len, rand64(), rand64(), rand64(), rand64());
                end
            endcase
            steady = (ph == 1 || ph == 4);
            target = items_sent + RANDOM_ITEMS / 6;
            while (items_sent < target) begin
                text_len = $urandom_range(1, 12);
                for (int k = 0; k < text_len; k++) begin
                    // half uniform bytes, half printable ASCII
                    b = $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(8'h20, 8'h7E));
                    // about one text in ten runs on without an end mark
                    send_byte(b, (k == text_len - 1) && ($urandom_range(0, 9) != 0));
                end
            end
        end
        steady = 1'b0;
        drain();

        $display("Sent %0d text bytes (%0d escaped) under %0d register settings;",
                 bytes_seen, escapes_seen, settings_used);
        $display("checked %0d output chars against the prediction.", chars_checked);
        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/upex_pkg.sv
hw/rtl/url_percent_encoder_xor.sv
hw/rtl/upex_chk.sv
verif/upex_checker.sv
verif/testbench.sv
